// ----- src/fixed_range_histogram_assert.svh -----
// Assertion macros for the histogram engine.
// Included by the RTL file that carries concurrent checks; needs no other file.
`ifndef FIXED_RANGE_HISTOGRAM_ASSERT_SVH
`define FIXED_RANGE_HISTOGRAM_ASSERT_SVH
`ifndef SYNTHESIS
`define FRH_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FRH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define FRH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FRH_ASSERT(label, clk, rst_n, prop, msg)
`define FRH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define FRH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/frh_pkg.sv -----
// Shared constants and codes of the histogram engine.
// Depends on nothing; imported by the top level.
`default_nettype none
package frh_pkg;
	localparam int NBINS       = 100;
	localparam int COUNT_WIDTH = 32;
	localparam int BIN_W       = $clog2(NBINS);
	localparam int QB          = $clog2(NBINS + 1);
	localparam int PCT_W       = 23;
	localparam int DVS_W       = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
	localparam int REM_W       = DVS_W + PCT_W;
	localparam int K_W         = $clog2(PCT_W);
	localparam int PCT_SCALE   = 6553600;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [2:0] ST_COUNTED = 3'd0;
	localparam logic [2:0] ST_OOR     = 3'd1;
	localparam logic [2:0] ST_READ    = 3'd2;
	localparam logic [2:0] ST_CLEARED = 3'd3;
	localparam logic [2:0] ST_BAD     = 3'd4;

	localparam logic [0:0] REG_X_MIN = 1'd0;
	localparam logic [0:0] REG_X_MAX = 1'd1;

	localparam logic [1:0] PH_BIN  = 2'd0;
	localparam logic [1:0] PH_PBIN = 2'd1;
	localparam logic [1:0] PH_PMAX = 2'd2;
endpackage
`default_nettype wire

// ----- src/frh_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module frh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- src/fixed_range_histogram.sv -----
// Uniform-bin histogram engine: bin store in RAM, shared restoring divider.
// An add is decoded, divided to find its bin, then the bin is read and updated. A read
// divides for bin and peak percent unless no samples are counted; clears, rejected adds
// and empty reads go straight to the result. Input is ready again as the result posts.
// Reset clears all bins at once through per-bin valid bits, and restores the range.
// Depends on frh_pkg, frh_ram and fixed_range_histogram_assert.svh.
`default_nettype none
`include "fixed_range_histogram_assert.svh"
module fixed_range_histogram
	import frh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // sample[31:0], bin_index[38:32], zero
	input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [79:0] m_axis_tdata,  // bin_percent, max_percent, total_count, zero
	output logic      [2:0]  m_axis_tuser,  // status[2:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_RMUL = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_BRD  = 3'd4;
	localparam logic [2:0] S_UPD  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [2:0]             state_q;
	logic signed [31:0]     x_min_q, x_max_q;
	logic [1:0]             cmd_q;
	logic signed [31:0]     smp_q;
	logic [6:0]             idx_q;
	logic [NBINS-1:0]       vld_q;
	logic [COUNT_WIDTH-1:0] total_q, largest_q;
	logic [REM_W-1:0]       rem_q;
	logic [DVS_W-1:0]       dvs_q;
	logic [K_W-1:0]         k_q;
	logic [PCT_W-1:0]       quo_q;
	logic [1:0]             ph_q;
	logic [BIN_W-1:0]       bin_q;
	logic [PCT_W-1:0]       bp_q;
	logic [2:0]             st_q;
	logic [PCT_W-1:0]       obp_q, omp_q;

	logic signed [32:0]     rng;
	logic                   bad_rng, oor;
	logic [32:0]            diff;
	logic                   idx_ok;
	logic [REM_W-1:0]       trial;
	logic                   fits;
	logic [REM_W-1:0]       rem_nx;
	logic [PCT_W-1:0]       quo_nx;
	logic [QB-1:0]          bin_raw;
	logic [BIN_W-1:0]       bin_cl;
	logic                   ram_we, ram_re;
	logic [BIN_W-1:0]       ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata, old_cnt, new_cnt, rd_cnt;
	logic [DVS_W-1:0]       tot_ext;
	logic [31:0]            tot_out;
	logic                   out_free;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	assign rng     = {x_max_q[31], x_max_q} - {x_min_q[31], x_min_q};
	assign bad_rng = rng[32] || (rng == 33'sd0);
	assign oor     = (smp_q < x_min_q) || (smp_q > x_max_q);
	assign diff    = {smp_q[31], smp_q} - {x_min_q[31], x_min_q};
	assign idx_ok  = (11'(idx_q) < 11'(NBINS));

	assign trial  = REM_W'(dvs_q) << k_q;
	assign fits   = (rem_q >= trial);
	assign rem_nx = fits ? (rem_q - trial) : rem_q;
	always_comb begin
		quo_nx = quo_q;
		quo_nx[k_q] = fits;
	end
	assign bin_raw = quo_nx[QB-1:0];
	assign bin_cl  = (11'(bin_raw) >= 11'(NBINS)) ? BIN_W'(NBINS - 1) : BIN_W'(bin_raw);

	assign ram_re    = ((state_q == S_DEC) && idx_ok) || (state_q == S_BRD);
	assign ram_raddr = (state_q == S_DEC) ? BIN_W'(idx_q) : bin_q;
	assign ram_we    = (state_q == S_UPD);
	assign old_cnt   = vld_q[bin_q] ? ram_rdata : '0;
	assign new_cnt   = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + 1'b1;
	assign rd_cnt    = (idx_ok && vld_q[BIN_W'(idx_q)]) ? ram_rdata : '0;

	assign tot_ext = DVS_W'(total_q);
	assign tot_out = (tot_ext > DVS_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : tot_ext[31:0];

	frh_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(NBINS)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(bin_q),
		.wdata(new_cnt),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= -32'sd655360;
			x_max_q <= 32'sd655360;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_MIN: x_min_q <= cfg_data;
				REG_X_MAX: x_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_q <= s_axis_tuser;
			smp_q <= s_axis_tdata[31:0];
			idx_q <= s_axis_tdata[38:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			vld_q         <= '0;
			total_q       <= '0;
			largest_q     <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					bp_q  <= '0;
					obp_q <= '0;
					omp_q <= '0;
					case (cmd_q)
						CMD_ADD: begin
							if (bad_rng) begin
								st_q    <= ST_BAD;
								state_q <= S_DONE;
							end else if (oor) begin
								st_q    <= ST_OOR;
								state_q <= S_DONE;
							end else begin
								rem_q   <= REM_W'(diff[31:0]) * REM_W'(NBINS);
								dvs_q   <= DVS_W'(rng[31:0]);
								k_q     <= K_W'(QB - 1);
								quo_q   <= '0;
								ph_q    <= PH_BIN;
								state_q <= S_DIV;
							end
						end
						CMD_CLEAR: begin
							vld_q     <= '0;
							total_q   <= '0;
							largest_q <= '0;
							st_q      <= ST_CLEARED;
							state_q   <= S_DONE;
						end
						default: begin
							st_q <= ST_READ;
							state_q <= (total_q == '0) ? S_DONE : S_RMUL;
						end
					endcase
				end
				S_RMUL: begin
					rem_q   <= REM_W'(rd_cnt) * REM_W'(PCT_SCALE);
					dvs_q   <= DVS_W'(total_q);
					k_q     <= K_W'(PCT_W - 1);
					quo_q   <= '0;
					ph_q    <= PH_PBIN;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					k_q   <= k_q - 1'b1;
					if (k_q == '0) begin
						case (ph_q)
							PH_BIN: begin
								bin_q   <= bin_cl;
								state_q <= S_BRD;
							end
							PH_PBIN: begin
								bp_q    <= quo_nx;
								rem_q   <= REM_W'(largest_q) * REM_W'(PCT_SCALE);
								k_q     <= K_W'(PCT_W - 1);
								quo_q   <= '0;
								ph_q    <= PH_PMAX;
							end
							default: begin
								obp_q   <= bp_q;
								omp_q   <= quo_nx;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_BRD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					vld_q[bin_q] <= 1'b1;
					if (new_cnt > largest_q) begin
						largest_q <= new_cnt;
					end
					if (total_q != CNT_MAX) begin
						total_q <= total_q + 1'b1;
					end
					st_q    <= ST_COUNTED;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			m_axis_tuser <= st_q;
			m_axis_tdata <= {2'b00, tot_out, omp_q, obp_q};
		end
	end

	`FRH_ASSERT(a_largest_le_total, clk, arst_n, largest_q <= total_q, "largest bin exceeds total")
	`FRH_ASSERT_NEXT(a_accept_decodes, clk, arst_n, s_axis_tvalid && s_axis_tready,
		state_q == S_DEC, "accepted item not decoded")
	`FRH_ASSERT_IMPL(a_upd_after_read, clk, arst_n, state_q == S_UPD,
		$past(state_q) == S_BRD, "bin update without read")
	`FRH_ASSERT_IMPL(a_counted_total, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser == ST_COUNTED), m_axis_tdata[77:46] != 32'd0,
		"counted result with zero total")
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the uniform-bin histogram engine.
// Drives add, read and clear commands with random burst and stall timing and
// checks every result against a behavioral histogram kept in this file; needs frh_pkg.
module tb_top
	import frh_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] sample;
		logic [6:0]  bin_index;
	} hist_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [22:0] bin_percent;
		logic [22:0] max_percent;
		logic [31:0] total_count;
	} hist_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = REG_X_MIN;
	logic [31:0] cfg_data = '0;

	fixed_range_histogram u_top (.*);

	always #5 clk = ~clk;

	hist_cmd_t   pending_cmds[$];
	hist_rsp_t   expected_rsps[$];
	longint      lo_edge, hi_edge;
	longint unsigned bin_store[NBINS];
	longint unsigned sample_total, peak_count;
	int          mismatches = 0;
	int          cycle_count = 0;
	int          burst_left = 0, gap_left = 0;
	logic        in_taken = 1'b0;
	localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;

	function automatic longint unsigned share_q16(longint unsigned cnt,
			longint unsigned tot);
		longint unsigned a, q, r;
		a = cnt * 100;
		q = a / tot;
		r = a % tot;
		return (q << 16) + ((r << 16) / tot);
	endfunction

	function automatic hist_rsp_t histogram_update(hist_cmd_t c);
		hist_rsp_t res;
		longint s, span;
		longint unsigned b, cnt;
		res = '0;
		s = longint'($signed(c.sample));
		if (c.cmd == CMD_ADD) begin
			span = hi_edge - lo_edge;
			if (span <= 0) begin
				res.status = ST_BAD;
			end else if (s < lo_edge || s > hi_edge) begin
				res.status = ST_OOR;
			end else begin
				b = (longint'(s - lo_edge) * NBINS) / span;
				if (b >= NBINS) b = NBINS - 1;
				if (bin_store[b] < CNT_MAX) bin_store[b]++;
				if (bin_store[b] > peak_count) peak_count = bin_store[b];
				if (sample_total < CNT_MAX) sample_total++;
				res.status = ST_COUNTED;
			end
		end else if (c.cmd == CMD_CLEAR) begin
			foreach (bin_store[i]) bin_store[i] = 0;
			sample_total = 0;
			peak_count = 0;
			res.status = ST_CLEARED;
		end else begin
			res.status = ST_READ;
			if (sample_total != 0) begin
				cnt = (c.bin_index < NBINS) ? bin_store[c.bin_index] : 0;
				res.bin_percent = 23'(share_q16(cnt, sample_total));
				res.max_percent = 23'(share_q16(peak_count, sample_total));
			end
		end
		res.total_count = sample_total[31:0];
		return res;
	endfunction

	// Input driver: bursts of transfers separated by random gaps; also drives the output ready.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !in_taken) begin
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				hist_cmd_t c;
				c = pending_cmds.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= c.cmd;
				s_axis_tdata <= {1'b0, c.bin_index, c.sample};
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
			case (($urandom_range(0, 3) == 0) ? (cycle_count / 500) % 3 : 3)
				0: m_axis_tready <= 1'b0;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= 1'b1;
			endcase
		end
	end

	// Input and output monitor.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			expected_rsps.push_back(histogram_update(
				{s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[38:32]}));
		if (m_axis_tvalid && m_axis_tready) begin
			hist_rsp_t got, exp_rsp;
			got = {m_axis_tuser, m_axis_tdata[22:0], m_axis_tdata[45:23],
				m_axis_tdata[77:46]};
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (got !== exp_rsp) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p actual %p", exp_rsp, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count > 3000000) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic write_range_reg(logic [0:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_X_MIN) lo_edge = longint'($signed(val));
		else hi_edge = longint'($signed(val));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_cmd(logic [1:0] cmd, logic [31:0] s, logic [6:0] idx);
		pending_cmds.push_back('{cmd, s, idx});
	endtask

	task automatic drain_queues();
		wait (pending_cmds.size() == 0);
		@(negedge clk);
		wait (!s_axis_tvalid);
		wait (expected_rsps.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_sample();
		longint span;
		span = hi_edge - lo_edge;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return lo_edge[31:0];
			2: return hi_edge[31:0];
			3: return lo_edge[31:0] - 1;
			default:
				if (span > 0)
					return 32'(lo_edge + longint'({$urandom, $urandom}
						% longint'(span + 1)));
				else return $urandom;
		endcase
	endfunction

	task automatic random_phase(int n);
		int k;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 19))
				0: queue_cmd(CMD_CLEAR, $urandom, 7'($urandom));
				1, 2, 3, 4: queue_cmd(CMD_READ, $urandom, 7'($urandom_range(0, 127)));
				5: queue_cmd(2'd3, $urandom, 7'($urandom_range(0, 127)));
				default: queue_cmd(CMD_ADD, pick_sample(), 7'($urandom));
			endcase
		end
		drain_queues();
	endtask

	initial begin
		int k;
		lo_edge = -655360;
		hi_edge = 655360;
		foreach (bin_store[i]) bin_store[i] = 0;
		sample_total = 0;
		peak_count = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reads before any sample, adds at the edges and just outside them, then reads and a clear.
		queue_cmd(CMD_READ, 0, 0);
		queue_cmd(CMD_ADD, 32'hFFF6_0000, 7'h7F);
		queue_cmd(CMD_ADD, 32'h000A_0000, 0);
		queue_cmd(CMD_ADD, 32'h000A_0001, 0);
		queue_cmd(CMD_ADD, 32'hFFF5_FFFF, 0);
		queue_cmd(CMD_ADD, 32'h8000_0000, 0);
		queue_cmd(CMD_ADD, 32'h7FFF_FFFF, 0);
		queue_cmd(CMD_ADD, 0, 0);
		queue_cmd(CMD_ADD, 0, 0);
		queue_cmd(CMD_READ, 0, 50);
		queue_cmd(CMD_READ, 0, 99);
		queue_cmd(CMD_READ, 0, 100);
		queue_cmd(CMD_READ, 32'hFFFF_FFFF, 7'h7F);
		queue_cmd(2'd3, 0, 0);
		queue_cmd(CMD_CLEAR, 0, 0);
		queue_cmd(CMD_READ, 0, 0);
		drain_queues();
		random_phase(250);

		// Full signed range.
		write_range_reg(REG_X_MIN, 32'h8000_0000);
		write_range_reg(REG_X_MAX, 32'h7FFF_FFFF);
		queue_cmd(CMD_ADD, 32'h8000_0000, 0);
		queue_cmd(CMD_ADD, 32'h7FFF_FFFF, 0);
		queue_cmd(CMD_READ, 0, 0);
		queue_cmd(CMD_READ, 0, 99);
		random_phase(250);

		// Bad ranges: equal edges, then inverted.
		write_range_reg(REG_X_MAX, 32'h8000_0000);
		queue_cmd(CMD_ADD, 32'h8000_0000, 0);
		random_phase(30);
		write_range_reg(REG_X_MIN, 32'h7FFF_FFFF);
		random_phase(30);

		// Narrow range smaller than the bin count.
		write_range_reg(REG_X_MIN, 32'd5);
		write_range_reg(REG_X_MAX, 32'd47);
		random_phase(250);

		for (k = 0; k < 2; k++) begin
			write_range_reg(REG_X_MIN, $urandom);
			write_range_reg(REG_X_MAX, $urandom);
			if (hi_edge <= lo_edge) write_range_reg(REG_X_MAX, 32'h7FFF_FFFF);
			random_phase(130);
		end

		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
